>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SPFL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SPFL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/spfl_pkg.sv
package spfl_pkg;

  localparam int POOL_SIZE = 32;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE) + 1;
  localparam int STEP_W    = $clog2(POOL_SIZE + 1);

  // A link value of POOL_SIZE terminates a list.
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SIZE);

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REINIT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_WALK,
    S_UNLINK,
    S_PUSH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ALLOC,
    WR_UNLINK,
    WR_PUSH
  } wr_op_t;

  typedef struct packed {
    logic    in_load;
    logic    reinit;
    logic    rd_en;
    logic    rd_cur;
    wr_op_t  wr_op;
    logic    walk_start;
    logic    walk_step;
    logic    hold_cur;
    logic    res_load;
    logic    res_grant;
    status_t res_status;
    logic    out_load;
  } spfl_cmd_t;

  typedef struct packed {
    logic free_empty;
    logic walk_over;
    logic cur_end;
    logic cur_hit;
  } spfl_stat_t;

  // Link held by an entry that was never written since the last restore.
  function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
    return LINK_W'(idx) + LINK_W'(1);
  endfunction

endpackage

>>> rtl/core/spfl_datapath.sv
module spfl_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  spfl_pkg::spfl_cmd_t       cmd,
  input  logic [spfl_pkg::SLOT_W-1:0] in_slot,
  output spfl_pkg::spfl_stat_t      stat,
  output logic [spfl_pkg::SLOT_W-1:0] out_slot,
  output spfl_pkg::status_t         out_status
);
  import spfl_pkg::*;

  logic [LINK_W-1:0] link_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld;

  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] used_head;
  logic [LINK_W-1:0] cur_reg;
  logic [LINK_W-1:0] prev;
  logic [STEP_W-1:0] steps;
  logic              use_link;
  logic [SLOT_W-1:0] slot_q;

  logic [LINK_W-1:0] rd_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic [SLOT_W-1:0] res_slot;
  status_t           res_status;

  logic [LINK_W-1:0] link_rd;
  logic [LINK_W-1:0] cur;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LINK_W-1:0] wr_data;

  // Entries not written since the last restore read as their reset link.
  assign link_rd = rd_vld_q ? rd_q : reset_link(rd_idx_q);
  assign cur     = use_link ? link_rd : cur_reg;
  assign rd_addr = cmd.rd_cur ? cur[IDX_W-1:0] : free_head[IDX_W-1:0];

  assign stat.free_empty = (free_head >= END_MARK);
  assign stat.walk_over  = (steps == STEP_W'(POOL_SIZE));
  assign stat.cur_end    = (cur >= END_MARK);
  assign stat.cur_hit    = (cur == LINK_W'(slot_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_head[IDX_W-1:0];
    wr_data = used_head;
    case (cmd.wr_op)
      WR_ALLOC: begin
        wr_en = 1'b1;
      end
      WR_UNLINK: begin
        wr_en   = (prev < END_MARK);
        wr_addr = prev[IDX_W-1:0];
        wr_data = link_rd;
      end
      WR_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = cur_reg[IDX_W-1:0];
        wr_data = free_head;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q     <= link_mem[rd_addr];
      rd_vld_q <= link_vld[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      link_vld  <= '0;
      free_head <= '0;
      used_head <= END_MARK;
    end else begin
      if (wr_en) begin
        link_vld[wr_addr] <= 1'b1;
      end
      case (cmd.wr_op)
        WR_ALLOC: begin
          free_head <= link_rd;
          used_head <= free_head;
        end
        WR_UNLINK: begin
          if (prev >= END_MARK) begin
            used_head <= link_rd;
          end
        end
        WR_PUSH: begin
          free_head <= cur_reg;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      slot_q <= in_slot;
    end
    if (cmd.walk_start) begin
      cur_reg  <= used_head;
      prev     <= END_MARK;
      steps    <= '0;
      use_link <= 1'b0;
    end else if (cmd.walk_step) begin
      prev     <= cur;
      steps    <= steps + STEP_W'(1);
      use_link <= 1'b1;
    end else if (cmd.hold_cur) begin
      cur_reg  <= cur;
      use_link <= 1'b0;
    end
    if (cmd.res_load) begin
      res_slot   <= cmd.res_grant ? SLOT_W'(free_head) : '0;
      res_status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_slot   <= res_slot;
      out_status <= res_status;
    end
  end

endmodule

>>> rtl/core/spfl_ctrl.sv
module spfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  spfl_pkg::spfl_stat_t stat,
  output spfl_pkg::spfl_cmd_t  cmd
);
  import spfl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          case (mode_t'(mode))
            MODE_ALLOC: begin
              state_next = S_ALLOC_RD;
            end
            MODE_FREE: begin
              cmd.walk_start = 1'b1;
              state_next     = S_WALK;
            end
            MODE_REINIT: begin
              cmd.reinit     = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_DONE;
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        if (stat.free_empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_EXHAUSTED;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_ALLOC_WR;
        end
      end
      S_ALLOC_WR: begin
        cmd.wr_op      = WR_ALLOC;
        cmd.res_load   = 1'b1;
        cmd.res_grant  = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_WALK: begin
        if (stat.walk_over || stat.cur_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_IN_USE;
          state_next     = S_DONE;
        end else if (stat.cur_hit) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_cur   = 1'b1;
          cmd.hold_cur = 1'b1;
          state_next   = S_UNLINK;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_cur    = 1'b1;
          cmd.walk_step = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd.wr_op  = WR_UNLINK;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.wr_op      = WR_PUSH;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/slot_pool_free_list_allocator_unit.sv
// Slot pool allocator: keeps 32 numbered slots on a free list and an in-use
// list that share one next-link memory.
// Input channel (s_*): one word per command. s_tuser carries the mode
// (allocate, free, reinitialize; the unused code does nothing) and s_tdata
// carries the slot number to release on a free.
// Output channel (m_*): exactly one word per command. m_tdata carries the
// granted slot (zero unless an allocate succeeded), m_tuser the status.
// Commands are processed one at a time; s_tready is high only while the
// controller is idle. An allocate passes through S_ALLOC_RD, S_ALLOC_WR
// (skipped when the free list is empty) and S_DONE. A free walks the in-use
// list one link per cycle through the registered memory read port.
// Reinitialize and the unused code go straight to S_DONE. The next command
// is accepted in the cycle after the result is loaded.
// A finished result sits in the output register; the next command is
// accepted while it waits, and a later result waits in the result registers
// until the output register is free, so a stalled receiver loses nothing.
// Reset (synchronous, active high) restores the lists at once: slot i links
// to slot i + 1, the free list starts at slot zero and the in-use list is
// empty. No clearing pass is needed.
module slot_pool_free_list_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] slot_number, [7:5] zero
  input  logic [1:0] s_tuser,   // [1:0] mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] granted_slot, [7:5] zero
  output logic [1:0] m_tuser    // [1:0] status
);
  import spfl_pkg::*;

  spfl_cmd_t         cmd;
  spfl_stat_t        stat;
  logic [SLOT_W-1:0] out_slot;
  status_t           out_status;

  // The controller sequences each command; the datapath holds the list heads,
  // the link memory with its per-entry valid bits, and the result registers.
  spfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spfl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_slot    (s_tdata[SLOT_W-1:0]),
    .stat       (stat),
    .out_slot   (out_slot),
    .out_status (out_status)
  );

  // Pad the granted slot up to a whole byte.
  assign m_tdata = {{(8 - SLOT_W){1'b0}}, out_slot};
  assign m_tuser = out_status;

endmodule

>>> rtl/core/spfl_checker.sv
`include "assert_macros.svh"

module spfl_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);
  import spfl_pkg::*;

  logic in_fire;
  logic stall;
  logic is_error;
  logic mode_seen;

  assign in_fire   = s_tvalid && s_tready;
  assign stall     = m_tvalid && !m_tready;
  assign is_error  = (m_tuser == ST_EXHAUSTED) || (m_tuser == ST_NOT_IN_USE);
  assign mode_seen = in_fire && (s_tuser == MODE_REINIT);

  // Only one command is in flight, so input stops right after an accept.
  `SPFL_ASSERT_NXT(a_one_in_flight, clk, rst, in_fire, !s_tready)

  // A failed command never hands out a slot number.
  `SPFL_ASSERT_IMP(a_error_no_grant, clk, rst, m_tvalid && is_error, m_tdata == 8'd0)

  // The status code is always one of the three defined values.
  `SPFL_ASSERT_IMP(a_status_legal, clk, rst, m_tvalid, m_tuser != 2'd3)

  // A stalled result word holds.
  `SPFL_ASSERT_NXT(a_out_hold, clk, rst, stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Reset leaves the block idle with no pending result.
  `SPFL_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid && s_tready)

  // A reinitialize command leaves the block busy in the cycle after it is taken.
  `SPFL_ASSERT_NXT(a_reinit_busy, clk, rst, mode_seen, !s_tready)

endmodule

bind slot_pool_free_list_allocator_unit spfl_checker u_spfl_checker (.*);

>>> tb/slot_pool_free_list_allocator_unit_test.sv
`timescale 1ns / 1ps

module slot_pool_free_list_allocator_unit_test;

  import spfl_pkg::*;

  // The mode code that the block must accept and ignore.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_WORDS   = 1500;
  localparam int CALM_WORDS     = 200;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [SLOT_W-1:0] grant;
    status_t           status;
  } reply_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [5:0]        reps;
    logic              given;
    logic [SLOT_W-1:0] grant;
    status_t           status;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [1:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;

  // Shadow of the slot lists, advanced once per accepted command word.
  logic [LINK_W-1:0] chain_next [POOL_SIZE];
  logic [LINK_W-1:0] in_use_top;
  logic [LINK_W-1:0] spare_top;

  reply_t pending_replies [$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  // Directed plan. Rows with given set carry a reply that is plain from the
  // reset lists; all other rows take their reply from the shadow lists.
  stim_row_t plan [0:17] = '{
    '{MODE_FREE,   5'd0,     6'd1,  1'b1, 5'd0, ST_NOT_IN_USE},  // empty in-use list
    '{MODE_ALLOC,  5'd7,     6'd1,  1'b1, 5'd0, ST_OK},
    '{MODE_ALLOC,  5'd0,     6'd1,  1'b0, 5'd0, ST_OK},
    '{MODE_FREE,   5'd31,    6'd1,  1'b1, 5'd0, ST_NOT_IN_USE},  // slot never handed out
    '{MODE_FREE,   5'd0,     6'd1,  1'b0, 5'd0, ST_OK},          // tail of the in-use list
    '{MODE_FREE,   5'd0,     6'd1,  1'b0, 5'd0, ST_OK},          // released twice
    '{MODE_SPARE,  5'd31,    6'd1,  1'b1, 5'd0, ST_OK},
    '{MODE_REINIT, 5'd21,    6'd1,  1'b1, 5'd0, ST_OK},
    '{MODE_ALLOC,  5'd0,     6'd32, 1'b0, 5'd0, ST_OK},          // drain the whole pool
    '{MODE_ALLOC,  5'd31,    6'd1,  1'b1, 5'd0, ST_EXHAUSTED},
    '{MODE_FREE,   5'd31,    6'd1,  1'b0, 5'd0, ST_OK},          // head of a full list
    '{MODE_FREE,   5'd0,     6'd1,  1'b0, 5'd0, ST_OK},          // longest walk
    '{MODE_FREE,   5'd16,    6'd1,  1'b0, 5'd0, ST_OK},
    '{MODE_FREE,   5'b10101, 6'd1,  1'b0, 5'd0, ST_OK},
    '{MODE_FREE,   5'b01010, 6'd1,  1'b0, 5'd0, ST_OK},
    '{MODE_ALLOC,  5'd0,     6'd6,  1'b0, 5'd0, ST_OK},          // refill, then exhaust
    '{MODE_REINIT, 5'd31,    6'd1,  1'b1, 5'd0, ST_OK},
    '{MODE_FREE,   5'd31,    6'd1,  1'b1, 5'd0, ST_NOT_IN_USE}
  };

  slot_pool_free_list_allocator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restore_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      chain_next[i] = (i + 1 < POOL_SIZE) ? LINK_W'(i + 1) : END_MARK;
    end
    in_use_top = END_MARK;
    spare_top  = LINK_W'(0);
  endfunction

  // Applies one command to the shadow lists and returns the reply it owes.
  function automatic reply_t pool_apply(input logic [1:0] mode, input logic [SLOT_W-1:0] slot);
    reply_t            r;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] taken;
    logic              done;
    int                n;
    r.grant  = '0;
    r.status = ST_OK;
    case (mode)
      MODE_ALLOC: begin
        if (spare_top >= LINK_W'(POOL_SIZE)) begin
          r.status = ST_EXHAUSTED;
        end else begin
          taken = spare_top;
          spare_top = chain_next[taken[IDX_W-1:0]];
          chain_next[taken[IDX_W-1:0]] = in_use_top;
          in_use_top = taken;
          r.grant = taken[SLOT_W-1:0];
        end
      end
      MODE_FREE: begin
        // The walk gives up after POOL_SIZE links, as the block does.
        r.status = ST_NOT_IN_USE;
        prev = END_MARK;
        cur  = in_use_top;
        done = 1'b0;
        for (n = 0; n < POOL_SIZE && !done; n++) begin
          if (cur >= LINK_W'(POOL_SIZE)) begin
            done = 1'b1;
          end else if (cur == LINK_W'(slot)) begin
            if (prev >= LINK_W'(POOL_SIZE)) begin
              in_use_top = chain_next[cur[IDX_W-1:0]];
            end else begin
              chain_next[prev[IDX_W-1:0]] = chain_next[cur[IDX_W-1:0]];
            end
            chain_next[cur[IDX_W-1:0]] = spare_top;
            spare_top = cur;
            r.status = ST_OK;
            done = 1'b1;
          end else begin
            prev = cur;
            cur  = chain_next[cur[IDX_W-1:0]];
          end
        end
      end
      MODE_REINIT: begin
        restore_pool();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Picks a slot that is currently handed out, or any slot if none is.
  function automatic logic [SLOT_W-1:0] pick_in_use_slot();
    logic [SLOT_W-1:0] held [$];
    logic [LINK_W-1:0] cur;
    int                n;
    cur = in_use_top;
    for (n = 0; n < POOL_SIZE && cur < LINK_W'(POOL_SIZE); n++) begin
      held.push_back(cur[SLOT_W-1:0]);
      cur = chain_next[cur[IDX_W-1:0]];
    end
    if (held.size() == 0) begin
      return SLOT_W'($urandom_range(0, POOL_SIZE - 1));
    end
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one command word, waits for the handshake and records the reply
  // it owes. A given reply replaces the shadow's, which still advances.
  task automatic send_command(input logic [1:0] mode, input logic [SLOT_W-1:0] slot,
                              input logic given, input reply_t typed);
    reply_t owed;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {3'b000, slot};
    do @(posedge clk); while (!s_tready);
    owed = pool_apply(mode, slot);
    pending_replies.push_back(given ? typed : owed);
  endtask

  initial begin : stimulus
    int                i;
    int                k;
    int                pick;
    int                alloc_bias;
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_ALLOC;
    alloc_bias = 50;
    restore_pool();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (k = 0; k < plan[r].reps; k++) begin
        send_command(plan[r].mode, plan[r].slot, plan[r].given,
                     '{plan[r].grant, plan[r].status});
      end
    end

    // Random part: windows that lean toward allocate fill the pool until it
    // runs dry, windows that lean toward free empty it again. Most frees name
    // a slot that is really handed out, so the walk goes to every depth.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) begin
        pick = $urandom_range(0, 2);
        alloc_bias = (pick == 0) ? 10 : (pick == 1) ? 50 : 90;
      end
      calm = (i >= RANDOM_WORDS - CALM_WORDS);
      pick = $urandom_range(0, 99);
      slot = SLOT_W'($urandom_range(0, POOL_SIZE - 1));
      if (pick < 2) begin
        mode = MODE_REINIT;
      end else if (pick < 4) begin
        mode = MODE_SPARE;
      end else if ($urandom_range(0, 99) < alloc_bias) begin
        mode = MODE_ALLOC;
      end else begin
        mode = MODE_FREE;
        if ($urandom_range(0, 4) != 0) begin
          slot = pick_in_use_slot();
        end
      end
      send_command(mode, slot, 1'b0, '{'0, ST_OK});
    end
    s_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS slot_pool_free_list_allocator_unit");
    end else begin
      $display("FAIL slot_pool_free_list_allocator_unit");
    end
    $finish;
  end

  // Receiver: ready drops at random, except near the end.
  initial begin : receiver
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none owed: tdata=%h tuser=%h", m_tdata, m_tuser));
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata !== {3'b000, want.grant}) begin
          report_mismatch($sformatf("granted slot: got tdata=%h, want %0d", m_tdata, want.grant));
        end
        if (m_tuser !== want.status) begin
          report_mismatch($sformatf("status: got %0d, want %0d", m_tuser, want.status));
        end
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL slot_pool_free_list_allocator_unit");
      $finish;
    end
  end

endmodule
